[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define SSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// shared types and constants of the stroke segment speed planner
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int COORD_BITS_DEF = 8;
    localparam int Q_DEPTH        = 2;

    localparam int PEN_W      = 2;
    localparam int WS_W       = 10;
    localparam int MPR_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int FRAC_BITS  = 8;
    localparam int SPEED_W    = 16;
    localparam int DUR_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OUT_FIELDS_W = 1 + SPEED_W + 1 + SPEED_W + 1 + DUR_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam int                MICRO_W = 20;
    localparam logic [MICRO_W-1:0] MICRO  = 20'd1000000;
    localparam int                RPM_K_W = 16;
    localparam logic [RPM_K_W-1:0] RPM_K  = 16'd60000;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [DUR_W-1:0]   DUR_MAX   = '1;

    localparam logic [WS_W-1:0]   WS_RESET   = 10'd10;
    localparam logic [MPR_W-1:0]  MPR_RESET  = 8'd8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRITE_SPEED = 2'd0,
        REG_MM_PER_REV  = 2'd1,
        REG_RPM_GAIN    = 2'd2,
        REG_TIME_GAIN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic pen;
        logic last;
        logic rev_x;
        logic rev_y;
    } t_seg_flags;

    typedef struct packed {
        logic               last;
        logic [DUR_W-1:0]   duration;
        logic               rev_y;
        logic [SPEED_W-1:0] speed_y;
        logic               rev_x;
        logic [SPEED_W-1:0] speed_x;
        logic               pen_change;
    } t_result;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SQ,
        BK_SCALE,
        BK_ROOT,
        BK_TSTART,
        BK_TWAIT,
        BK_DUR,
        BK_DEN,
        BK_ASTART,
        BK_AWAIT,
        BK_AGAIN,
        BK_ASAT,
        BK_OUT
    } t_back_state;

endpackage

[rtl/ssp_fifo.sv]
// ----------------------------------------------------------------------------
// ssp_fifo
// short segment queue between the front end and the back end
// ----------------------------------------------------------------------------
module ssp_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/ssp_front.sv]
// ----------------------------------------------------------------------------
// ssp_front
// takes stroke points, keeps the previous point, queues one or two segments
// ----------------------------------------------------------------------------
module ssp_front
    import ssp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [PEN_W-1:0]      i_pen,
    input  logic                  i_last,
    output logic                  o_push,
    output logic [COORD_BITS-1:0] o_ax,
    output logic [COORD_BITS-1:0] o_ay,
    output t_seg_flags            o_flags,
    input  logic                  i_full
);

    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic [PEN_W-1:0]      r_prev_pen;
    logic                  r_have;
    logic                  r_pend;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic                  accept;

    assign o_ready = !r_pend && !i_full;
    assign accept  = i_valid && o_ready;
    assign x1      = r_have ? r_prev_x : '0;
    assign y1      = r_have ? r_prev_y : '0;

    always_comb begin
        if (r_pend) begin
            // return to origin after the last point
            o_push        = !i_full;
            o_ax          = r_prev_x;
            o_ay          = r_prev_y;
            o_flags.pen   = (r_prev_pen != '0);
            o_flags.last  = 1'b1;
            o_flags.rev_x = 1'b0;
            o_flags.rev_y = 1'b0;
        end else begin
            o_push        = accept;
            o_ax          = (i_x >= x1) ? i_x - x1 : x1 - i_x;
            o_ay          = (i_y >= y1) ? i_y - y1 : y1 - i_y;
            o_flags.pen   = r_have && (r_prev_pen != '0);
            o_flags.last  = !i_last;
            o_flags.rev_x = (i_x > x1);
            o_flags.rev_y = (i_y > y1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_pen <= '0;
            r_have     <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_x   <= i_x;
                r_prev_y   <= i_y;
                r_prev_pen <= i_pen;
                r_have     <= !i_last;
                r_pend     <= i_last;
            end else if (r_pend && !i_full) begin
                r_pend <= 1'b0;
            end
        end
    end

endmodule

[rtl/ssp_div.sv]
// ----------------------------------------------------------------------------
// ssp_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssp_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {r_rem, r_q[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

[rtl/ssp_back.sv]
// ----------------------------------------------------------------------------
// ssp_back
// per segment: length by square root, duration and axis speeds by division
// ----------------------------------------------------------------------------
module ssp_back
    import ssp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    input  logic [COORD_BITS-1:0] i_q_ax,
    input  logic [COORD_BITS-1:0] i_q_ay,
    input  t_seg_flags            i_q_flags,
    input  logic [WS_W-1:0]       i_write_speed,
    input  logic [MPR_W-1:0]      i_mm_per_rev,
    input  logic [GAIN_W-1:0]     i_rpm_gain,
    input  logic [GAIN_W-1:0]     i_time_gain,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_res
);

    localparam int SQ_W      = 2 * COORD_BITS + 1;
    localparam int PROD_W    = SQ_W + MICRO_W;
    localparam int LEN_W     = (PROD_W + 1) / 2;
    localparam int ROOT_IN_W = 2 * LEN_W;
    localparam int NUMR_W    = COORD_BITS + RPM_K_W;
    localparam int DIV_NUM_W = (LEN_W > NUMR_W) ? LEN_W : NUMR_W;
    localparam int DEN_W     = LEN_W + MPR_W;
    localparam int TPROD_W   = LEN_W + GAIN_W;
    localparam int GPROD_W   = DIV_NUM_W + GAIN_W;
    localparam int STEP_W    = $clog2(LEN_W);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [COORD_BITS-1:0] r_ax;
    logic [COORD_BITS-1:0] r_ay;
    t_seg_flags            r_flags;
    logic [SQ_W-1:0]       r_sum;
    logic [ROOT_IN_W-1:0]  r_prod;
    logic [LEN_W:0]        r_rem;
    logic [LEN_W-1:0]      r_root;
    logic [STEP_W-1:0]     r_step;
    logic [LEN_W-1:0]      r_t;
    logic [TPROD_W-1:0]    r_tprod;
    logic [DUR_W-1:0]      r_dur;
    logic [DEN_W-1:0]      r_den;
    logic                  r_axis;
    logic [DIV_NUM_W-1:0]  r_rpm;
    logic [GPROD_W-1:0]    r_gprod;
    logic [SPEED_W-1:0]    r_spd_x;
    logic [SPEED_W-1:0]    r_spd_y;
    logic                  r_ovalid;
    t_result               r_res;

    logic [2*COORD_BITS-1:0] sq_x;
    logic [2*COORD_BITS-1:0] sq_y;
    logic [PROD_W-1:0]       scale_prod;
    logic [LEN_W+2:0]        root_sh;
    logic [LEN_W+2:0]        root_trial;
    logic                    root_ge;
    logic [COORD_BITS-1:0]   axis_d;
    logic [NUMR_W-1:0]       axis_num;
    logic [63:0]             dur_wide;
    logic [63:0]             spd_wide;
    logic [SPEED_W-1:0]      spd_sat;
    logic                    out_free;
    logic                    div_start;
    logic [DIV_NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic [DIV_NUM_W-1:0]    div_quot;

    assign sq_x       = r_ax * r_ax;
    assign sq_y       = r_ay * r_ay;
    assign scale_prod = PROD_W'(r_sum) * PROD_W'(MICRO);
    assign root_sh    = {r_rem, r_prod[ROOT_IN_W-1 -: 2]};
    assign root_trial = {1'b0, r_root, 2'b01};
    assign root_ge    = (root_sh >= root_trial);
    assign axis_d     = r_axis ? r_ay : r_ax;
    assign axis_num   = NUMR_W'(axis_d) * NUMR_W'(RPM_K);
    assign dur_wide   = 64'(r_tprod[TPROD_W-1:FRAC_BITS]);
    assign spd_wide   = 64'(r_gprod[GPROD_W-1:FRAC_BITS]);
    assign spd_sat    = (spd_wide > 64'(SPEED_MAX)) ? SPEED_MAX : spd_wide[SPEED_W-1:0];
    assign out_free   = !r_ovalid || i_ready;
    assign o_valid    = r_ovalid;
    assign o_res      = r_res;

    ssp_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(axis_num);
        div_den   = r_den;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = BK_SQ;
                end
            end
            BK_SQ:    n_state = BK_SCALE;
            BK_SCALE: n_state = BK_ROOT;
            BK_ROOT: begin
                if (r_step == STEP_W'(LEN_W - 1)) begin
                    n_state = BK_TSTART;
                end
            end
            BK_TSTART: begin
                div_num = DIV_NUM_W'(r_root);
                div_den = DEN_W'(i_write_speed);
                if (i_write_speed == '0) begin
                    n_state = BK_DUR;
                end else begin
                    div_start = 1'b1;
                    n_state   = BK_TWAIT;
                end
            end
            BK_TWAIT: begin
                if (div_done) begin
                    n_state = BK_DUR;
                end
            end
            BK_DUR: n_state = BK_DEN;
            BK_DEN: n_state = BK_ASTART;
            BK_ASTART: begin
                if (r_den == '0) begin
                    n_state = BK_AGAIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = BK_AWAIT;
                end
            end
            BK_AWAIT: begin
                if (div_done) begin
                    n_state = BK_AGAIN;
                end
            end
            BK_AGAIN: n_state = BK_ASAT;
            BK_ASAT:  n_state = r_axis ? BK_OUT : BK_ASTART;
            BK_OUT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_ax    <= i_q_ax;
                r_ay    <= i_q_ay;
                r_flags <= i_q_flags;
            end
            BK_SQ: begin
                r_sum <= SQ_W'(sq_x) + SQ_W'(sq_y);
            end
            BK_SCALE: begin
                r_prod <= ROOT_IN_W'(scale_prod);
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            BK_ROOT: begin
                r_rem  <= (LEN_W + 1)'(root_ge ? root_sh - root_trial : root_sh);
                r_root <= {r_root[LEN_W-2:0], root_ge};
                r_prod <= r_prod << 2;
                r_step <= r_step + 1'b1;
            end
            BK_TSTART: begin
                r_t <= '0;
            end
            BK_TWAIT: begin
                if (div_done) begin
                    r_t <= div_quot[LEN_W-1:0];
                end
            end
            BK_DUR: begin
                r_tprod <= TPROD_W'(r_t) * TPROD_W'(i_time_gain);
            end
            BK_DEN: begin
                r_dur  <= (dur_wide > 64'(DUR_MAX)) ? DUR_MAX : dur_wide[DUR_W-1:0];
                r_den  <= DEN_W'(r_t) * DEN_W'(i_mm_per_rev);
                r_axis <= 1'b0;
            end
            BK_ASTART: begin
                r_rpm <= '0;
            end
            BK_AWAIT: begin
                if (div_done) begin
                    r_rpm <= div_quot;
                end
            end
            BK_AGAIN: begin
                r_gprod <= GPROD_W'(r_rpm) * GPROD_W'(i_rpm_gain);
            end
            BK_ASAT: begin
                if (r_axis) begin
                    r_spd_y <= spd_sat;
                end else begin
                    r_spd_x <= spd_sat;
                    r_axis  <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_OUT && out_free) begin
            r_res.pen_change <= r_flags.pen;
            r_res.speed_x    <= r_spd_x;
            r_res.rev_x      <= r_flags.rev_x;
            r_res.speed_y    <= r_spd_y;
            r_res.rev_y      <= r_flags.rev_y;
            r_res.duration   <= r_dur;
            r_res.last       <= r_flags.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == BK_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

[rtl/stroke_segment_speed_planner_top.sv]
// ----------------------------------------------------------------------------
// stroke_segment_speed_planner_top
// throughput: one segment per point, two for a last point; the back end works on
//   one segment at a time, set by the shared bit-serial divider and square-root
//   sequencer, and stalls while the output is held; the queue takes points meanwhile
// reset: synchronous, clears queue, previous point and output; registers to
//   their defaults
// ----------------------------------------------------------------------------
module stroke_segment_speed_planner_top
    import ssp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pen_action, zero fill
    input  logic [((2*COORD_BITS+PEN_W+7)/8)*8-1:0] s_axis_tdata,
    // is_last
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pen_change, speed_x, reverse_x, speed_y, reverse_y, duration_ms, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // last_of_run
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int Q_W = 2 * COORD_BITS + $bits(t_seg_flags);

    logic [WS_W-1:0]       r_write_speed;
    logic [MPR_W-1:0]      r_mm_per_rev;
    logic [GAIN_W-1:0]     r_rpm_gain;
    logic [GAIN_W-1:0]     r_time_gain;

    logic                  push;
    logic [COORD_BITS-1:0] push_ax;
    logic [COORD_BITS-1:0] push_ay;
    t_seg_flags            push_flags;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [Q_W-1:0]        q_data;
    logic [COORD_BITS-1:0] q_ax;
    logic [COORD_BITS-1:0] q_ay;
    t_seg_flags            q_flags;
    t_result               res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_speed <= WS_RESET;
            r_mm_per_rev  <= MPR_RESET;
            r_rpm_gain    <= GAIN_RESET;
            r_time_gain   <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                REG_WRITE_SPEED: r_write_speed <= i_cfg_wdata[WS_W-1:0];
                REG_MM_PER_REV:  r_mm_per_rev  <= i_cfg_wdata[MPR_W-1:0];
                REG_RPM_GAIN:    r_rpm_gain    <= i_cfg_wdata[GAIN_W-1:0];
                REG_TIME_GAIN:   r_time_gain   <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[COORD_BITS-1:0]),
        .i_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_pen   (s_axis_tdata[2*COORD_BITS+PEN_W-1:2*COORD_BITS]),
        .i_last  (s_axis_tlast),
        .o_push  (push),
        .o_ax    (push_ax),
        .o_ay    (push_ay),
        .o_flags (push_flags),
        .i_full  (q_full)
    );

    ssp_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ax, push_ay, push_flags}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign {q_ax, q_ay, q_flags} = q_data;

    ssp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_q_ax        (q_ax),
        .i_q_ay        (q_ay),
        .i_q_flags     (q_flags),
        .i_write_speed (r_write_speed),
        .i_mm_per_rev  (r_mm_per_rev),
        .i_rpm_gain    (r_rpm_gain),
        .i_time_gain   (r_time_gain),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_res         (res)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.duration, res.rev_y, res.speed_y,
                           res.rev_x, res.speed_x, res.pen_change};
    assign m_axis_tlast = res.last;

endmodule

[rtl/ssp_checker.sv]
// ----------------------------------------------------------------------------
// ssp_checker
// port-level checks on the planner, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssp_checker
    import ssp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // stalled result holds
    `SSP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // reset empties the output stage
    `SSP_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // reset leaves the queue empty, so input is taken right away
    `SSP_ASSERT_ALWAYS(a_rst_in, !i_rst_n |=> s_axis_tready, "input not ready after reset")

    // fill bits of a result stay zero
    `SSP_ASSERT(a_out_pad, m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0, "nonzero fill bits in result")

endmodule

bind stroke_segment_speed_planner_top ssp_checker u_ssp_checker (.*);

[bench/stroke_segment_speed_planner_top_tb.sv]
// ----------------------------------------------------------------------------
// stroke_segment_speed_planner_top_tb
// Sends stroke points into the planner and checks every segment it returns
// against a predictor kept in step with the accepted points. Directed strokes
// and register extremes come first, then random strokes under random register
// settings with random idling on both streams, a long output stall that backs
// up the input, and a final stretch with no idling.
// ----------------------------------------------------------------------------
module stroke_segment_speed_planner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssp_pkg::*;

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int IN_W         = ((2*COORD_W+PEN_W+7)/8)*8;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic               pen_change;
        logic [SPEED_W-1:0] speed_x;
        logic               rev_x;
        logic [SPEED_W-1:0] speed_y;
        logic               rev_y;
        logic [DUR_W-1:0]   duration;
        logic               run_end;
    } t_seg_plan;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;        // pos_x, pos_y, pen_action, zero fill
    logic                  s_axis_tlast;        // is_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // pen_change, speed_x, reverse_x, speed_y,
                                                // reverse_y, duration_ms, zero fill
    logic                  m_axis_tlast;        // last_of_run
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    stroke_segment_speed_planner_top uut (.*);

    // predictor state and register copies
    logic [WS_W-1:0]    cfg_ws;
    logic [MPR_W-1:0]   cfg_mpr;
    logic [GAIN_W-1:0]  cfg_rgain;
    logic [GAIN_W-1:0]  cfg_tgain;
    logic [COORD_W-1:0] pl_prev_x;
    logic [COORD_W-1:0] pl_prev_y;
    logic [PEN_W-1:0]   pl_prev_pen;
    logic               pl_have_prev;

    t_seg_plan plan_q[$];

    int  fail_count;
    int  points_sent;
    int  segs_checked;
    int  settings_used;
    int  hold_requests;
    int  hold_served;
    bit  src_idle_on;
    bit  sink_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("stroke_segment_speed_planner_top_tb failed");
        $finish;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] motor_rpm(longint unsigned axis_len,
                                                     longint unsigned t_ms);
        longint unsigned rpm;
        longint unsigned adj;
        if (t_ms == 0 || cfg_mpr == 0) return '0;
        rpm = (axis_len * 64'd60000) / (t_ms * cfg_mpr);
        adj = (rpm * cfg_rgain) >> FRAC_BITS;
        return (adj > SPEED_MAX) ? SPEED_MAX : adj[SPEED_W-1:0];
    endfunction

    function automatic t_seg_plan plan_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                               logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                                               logic pen, logic run_end);
        t_seg_plan s;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned len_um;
        longint unsigned t_ms;
        longint unsigned dur;
        dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
        len_um = floor_root((dx * dx + dy * dy) * 64'd1000000);
        t_ms = (cfg_ws == 0) ? 0 : len_um / cfg_ws;
        dur = (t_ms * cfg_tgain) >> FRAC_BITS;
        s.pen_change = pen;
        s.speed_x    = motor_rpm(dx, t_ms);
        s.rev_x      = x1 > x0;
        s.speed_y    = motor_rpm(dy, t_ms);
        s.rev_y      = y1 > y0;
        s.duration   = (dur > DUR_MAX) ? DUR_MAX : dur[DUR_W-1:0];
        s.run_end    = run_end;
        return s;
    endfunction

    task automatic predict_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [PEN_W-1:0] pen, logic is_end);
        if (pl_have_prev)
            plan_q.push_back(plan_segment(pl_prev_x, pl_prev_y, x, y, pl_prev_pen != 0, !is_end));
        else
            plan_q.push_back(plan_segment('0, '0, x, y, 1'b0, !is_end));
        if (is_end)
            plan_q.push_back(plan_segment(x, y, '0, '0, pen != 0, 1'b1));
        pl_have_prev = !is_end;
        pl_prev_x    = x;
        pl_prev_y    = y;
        pl_prev_pen  = pen;
    endtask

    // valid is left high after a request so back-to-back points keep it steady
    task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [PEN_W-1:0] pen, logic is_end);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-2*COORD_W-PEN_W){1'b0}}, pen, y, x};
        s_axis_tlast  <= is_end;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_point(x, y, pen, is_end);
        points_sent++;
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (plan_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [WS_W-1:0] ws, logic [MPR_W-1:0] mpr,
                                  logic [GAIN_W-1:0] rg, logic [GAIN_W-1:0] tg);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_WRITE_SPEED;
        i_cfg_wdata <= CFG_DATA_W'(ws);
        @(posedge i_clk);
        i_cfg_addr  <= REG_MM_PER_REV;
        i_cfg_wdata <= CFG_DATA_W'(mpr);
        @(posedge i_clk);
        i_cfg_addr  <= REG_RPM_GAIN;
        i_cfg_wdata <= rg;
        @(posedge i_clk);
        i_cfg_addr  <= REG_TIME_GAIN;
        i_cfg_wdata <= tg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_ws    = ws;
        cfg_mpr   = mpr;
        cfg_rgain = rg;
        cfg_tgain = tg;
        settings_used++;
        @(posedge i_clk);
    endtask

    function automatic logic [PEN_W-1:0] pick_pen();
        int r;
        r = $urandom_range(0, 19);
        return (r == 0) ? PEN_W'(3) : PEN_W'(r % 3);
    endfunction

    task automatic random_settings();
        logic [WS_W-1:0]   ws;
        logic [MPR_W-1:0]  mpr;
        logic [GAIN_W-1:0] rg;
        logic [GAIN_W-1:0] tg;
        case ($urandom_range(0, 5))
            0: ws = '0;
            1: ws = WS_W'(1);
            2: ws = '1;
            default: ws = WS_W'($urandom_range(1, 1023));
        endcase
        case ($urandom_range(0, 5))
            0: mpr = '0;
            1: mpr = MPR_W'(1);
            2: mpr = '1;
            default: mpr = MPR_W'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 4))
            0: rg = '0;
            1: rg = '1;
            2: rg = GAIN_RESET;
            default: rg = GAIN_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: tg = '0;
            1: tg = '1;
            2: tg = GAIN_RESET;
            default: tg = GAIN_W'($urandom);
        endcase
        apply_settings(ws, mpr, rg, tg);
    endtask

    // mostly well-formed strokes ending on a last point; some carry stray last marks
    task automatic random_stroke();
        int                 n;
        bit                 noisy;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               is_end;
        n = $urandom_range(1, 12);
        noisy = ($urandom_range(0, 9) == 0);
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                x = x + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
                y = y + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
            end else begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            is_end = (i == n - 1) || (noisy && $urandom_range(0, 3) == 0);
            send_point(x, y, pick_pen(), is_end);
        end
    endtask

    task automatic test_directed_strokes();
        send_point(8'd0,   8'd0,   2'd0, 1'b1);
        send_point(8'd255, 8'd255, 2'd1, 1'b1);
        send_point(8'd10,  8'd20,  2'd1, 1'b0);
        send_point(8'd200, 8'd5,   2'd2, 1'b0);
        send_point(8'd200, 8'd5,   2'd0, 1'b0);
        send_point(8'd0,   8'd255, 2'd3, 1'b0);
        send_point(8'd255, 8'd0,   2'd0, 1'b1);
        send_point(8'd128, 8'd64,  2'd2, 1'b0);
        send_point(8'd64,  8'd128, 2'd1, 1'b1);
        quiesce();
    endtask

    task automatic test_register_extremes();
        apply_settings(WS_W'(0), MPR_RESET, GAIN_RESET, GAIN_RESET);
        send_point(8'd100, 8'd50,  2'd1, 1'b0);
        send_point(8'd3,   8'd200, 2'd2, 1'b1);
        quiesce();
        apply_settings('1, MPR_W'(0), GAIN_RESET, GAIN_RESET);
        send_point(8'd1,   8'd1,   2'd0, 1'b0);
        send_point(8'd255, 8'd0,   2'd1, 1'b1);
        quiesce();
        apply_settings(WS_W'(1), MPR_W'(1), '1, '1);
        send_point(8'd255, 8'd255, 2'd1, 1'b0);
        send_point(8'd0,   8'd0,   2'd2, 1'b0);
        send_point(8'd1,   8'd0,   2'd0, 1'b1);
        quiesce();
        apply_settings('1, '1, '0, '0);
        send_point(8'd17,  8'd34,  2'd1, 1'b1);
        quiesce();
        apply_settings(WS_W'(1000), '1, '1, GAIN_W'(1));
        send_point(8'd2,   8'd0,   2'd0, 1'b0);
        send_point(8'd0,   8'd0,   2'd0, 1'b1);
        quiesce();
    endtask

    task automatic test_random_settings(int phases, int per_phase);
        int start;
        for (int p = 0; p < phases; p++) begin
            random_settings();
            start = points_sent;
            while (points_sent - start < per_phase) random_stroke();
            quiesce();
        end
    endtask

    task automatic test_output_backpressure();
        src_idle_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 24; i++)
            send_point(COORD_W'($urandom), COORD_W'($urandom), pick_pen(),
                       $urandom_range(0, 4) == 0);
        quiesce();
        src_idle_on = 1'b1;
    endtask

    task automatic test_steady_stream(int count);
        int start;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        random_settings();
        start = points_sent;
        while (points_sent - start < count) random_stroke();
        quiesce();
    endtask

    // output side: random stalls, plus one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_seg_plan want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (plan_q.size() == 0) begin
                $error("segment with no request waiting");
                fail_count++;
            end else begin
                want = plan_q.pop_front();
                segs_checked++;
                check_field("pen_change",  want.pen_change, m_axis_tdata[0]);
                check_field("speed_x",     want.speed_x,    m_axis_tdata[16:1]);
                check_field("reverse_x",   want.rev_x,      m_axis_tdata[17]);
                check_field("speed_y",     want.speed_y,    m_axis_tdata[33:18]);
                check_field("reverse_y",   want.rev_y,      m_axis_tdata[34]);
                check_field("duration_ms", want.duration,   m_axis_tdata[58:35]);
                check_field("last_of_run", want.run_end,    m_axis_tlast);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_WRITE_SPEED;
        i_cfg_wdata   = '0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        fail_count    = 0;
        points_sent   = 0;
        segs_checked  = 0;
        settings_used = 0;
        hold_requests = 0;
        hold_served   = 0;
        cfg_ws        = WS_RESET;
        cfg_mpr       = MPR_RESET;
        cfg_rgain     = GAIN_RESET;
        cfg_tgain     = GAIN_RESET;
        pl_prev_x     = '0;
        pl_prev_y     = '0;
        pl_prev_pen   = '0;
        pl_have_prev  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_strokes();
        test_register_extremes();
        test_random_settings(6, 170);
        test_output_backpressure();
        test_steady_stream(250);

        $display("run covered %0d points and %0d segments under %0d register settings",
                 points_sent, segs_checked, settings_used + 1);
        $display("including zero and saturating gains and a %0d cycle output hold",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("stroke_segment_speed_planner_top_tb passed");
        end else begin
            $display("stroke_segment_speed_planner_top_tb failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_fifo.sv
rtl/ssp_front.sv
rtl/ssp_div.sv
rtl/ssp_back.sv
rtl/stroke_segment_speed_planner_top.sv
rtl/ssp_checker.sv
bench/stroke_segment_speed_planner_top_tb.sv
